@@ rtl/mvt_pkg.sv @@
// shared types, constants and helpers of the 4x4 matrix-vector transform
package mvt_pkg;

	localparam int DIM         = 4;
	localparam int ROW_W       = $clog2(DIM);
	localparam int COMP_W      = 32;
	localparam int FRAC_W      = 16;
	localparam int PROD_W      = 2 * COMP_W;
	localparam int PAIR_W      = PROD_W + 1;
	localparam int SUM_W       = PROD_W + 2;
	localparam int SHIFT_W     = SUM_W - FRAC_W;
	localparam int QUEUE_DEPTH = 4;

	// one in q16.16
	localparam logic [COMP_W-1:0] Q_ONE = COMP_W'(1) << FRAC_W;
	localparam logic [COMP_W-1:0] Q_MAX = {1'b0, {(COMP_W-1){1'b1}}};
	localparam logic [COMP_W-1:0] Q_MIN = {1'b1, {(COMP_W-1){1'b0}}};

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_XFORM = 1'b1
	} opcode_t;

	// classified item handed from front to back
	typedef struct packed {
		logic                         is_load;
		logic [ROW_W-1:0]             row;
		logic [DIM-1:0][COMP_W-1:0]   comp;
	} cmd_t;

	// queue status seen at the top level
	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} q_stat_t;

	// clamp a floor-shifted sum into the signed 32-bit range
	function automatic logic [COMP_W-1:0] sat_q16(input logic [SHIFT_W-1:0] v);
		logic [SHIFT_W-COMP_W:0] top;
		top = v[SHIFT_W-1:COMP_W-1];
		if (top == '0 || top == '1) begin
			return v[COMP_W-1:0];
		end else if (v[SHIFT_W-1]) begin
			return Q_MIN;
		end else begin
			return Q_MAX;
		end
	endfunction

endpackage

@@ rtl/mvt_if.sv @@
// valid/ready channel interfaces for input items and result items
interface mvt_in_if import mvt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [ROW_W-1:0]    row_select;
	logic signed [COMP_W-1:0] comp_x;
	logic signed [COMP_W-1:0] comp_y;
	logic signed [COMP_W-1:0] comp_z;
	logic signed [COMP_W-1:0] comp_w;

	modport source (output valid, opcode, row_select, comp_x, comp_y, comp_z, comp_w,
		input ready);
	modport sink (input valid, opcode, row_select, comp_x, comp_y, comp_z, comp_w,
		output ready);
endinterface

interface mvt_out_if import mvt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic signed [COMP_W-1:0] out_x;
	logic signed [COMP_W-1:0] out_y;
	logic signed [COMP_W-1:0] out_z;
	logic signed [COMP_W-1:0] out_w;

	modport source (output valid, out_x, out_y, out_z, out_w, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

@@ rtl/mvt_front.sv @@
// front end: accepts items, classifies them and registers them for the queue
module mvt_front import mvt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mvt_in_if.sink    in,
	output logic      cmd_valid,
	output cmd_t      cmd,
	input  logic      cmd_ready
);

	logic cmd_valid_q;
	cmd_t cmd_q;
	cmd_t cmd_d;
	logic accept;

	// register frees up whenever the queue takes its item
	assign in.ready = !cmd_valid_q || cmd_ready;
	assign accept   = in.valid && in.ready;

	// classify the item
	always_comb begin
		cmd_d.is_load = (in.opcode == OP_LOAD);
		cmd_d.row     = in.row_select;
		cmd_d.comp[0] = in.comp_x;
		cmd_d.comp[1] = in.comp_y;
		cmd_d.comp[2] = in.comp_z;
		cmd_d.comp[3] = in.comp_w;
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (in.ready) begin
			cmd_valid_q <= in.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_d;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

endmodule

@@ rtl/mvt_queue.sv @@
// short first-in first-out queue between front and back (power-of-two depth)
module mvt_queue import mvt_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  cmd_t    in_cmd,
	output logic    in_ready,
	output logic    out_valid,
	output cmd_t    out_cmd,
	input  logic    out_ready,
	output q_stat_t stat
);

	localparam int AW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;

	assign full  = (count_q == CW'(Depth));
	assign empty = (count_q == '0);
	assign push  = in_valid && !full;
	assign pop   = out_valid && out_ready;

	assign in_ready  = !full;
	assign out_valid = !empty;
	assign out_cmd   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	assign stat = '{push: push, pop: pop, full: full, empty: empty};

endmodule

@@ rtl/mvt_back.sv @@
// back end: holds the matrix, applies row loads and runs the dot-product pipeline
module mvt_back import mvt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_ready,
	mvt_out_if.source out
);

	logic [COMP_W-1:0]        mat_q  [DIM][DIM];
	logic signed [PROD_W-1:0] prod_s1 [DIM][DIM];
	logic signed [PAIR_W-1:0] pair_s2 [DIM][2];
	logic [COMP_W-1:0]        res_s3 [DIM];
	logic [COMP_W-1:0]        res_q  [DIM];
	logic signed [SUM_W-1:0]  sum_d  [DIM];
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic out_free, s3_ready, s2_ready, s1_ready;
	logic take;

	// per-stage ready chain
	assign out_free  = !out_valid_q || out.ready;
	assign s3_ready  = !v_s3 || out_free;
	assign s2_ready  = !v_s2 || s3_ready;
	assign s1_ready  = !v_s1 || s2_ready;
	assign cmd_ready = s1_ready;
	assign take      = cmd_valid && s1_ready;

	// matrix, identity after reset, one row written per load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					mat_q[r][c] <= (r == c) ? Q_ONE : '0;
				end
			end
		end else if (take && cmd.is_load) begin
			for (int c = 0; c < DIM; c++) begin
				mat_q[cmd.row][c] <= cmd.comp[c];
			end
		end
	end

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= take && !cmd.is_load;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
			if (s3_ready) begin
				v_s3 <= v_s2;
			end
			if (out_free) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// stage 1: sixteen 32x32 products
	always_ff @(posedge clk) begin
		if (s1_ready) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					prod_s1[r][c] <= $signed(mat_q[r][c]) * $signed(cmd.comp[c]);
				end
			end
		end
	end

	// stage 2: pairwise sums per row
	always_ff @(posedge clk) begin
		if (s2_ready) begin
			for (int r = 0; r < DIM; r++) begin
				pair_s2[r][0] <= PAIR_W'(prod_s1[r][0]) + PAIR_W'(prod_s1[r][1]);
				pair_s2[r][1] <= PAIR_W'(prod_s1[r][2]) + PAIR_W'(prod_s1[r][3]);
			end
		end
	end

	// stage 3: full sum, floor shift by the fraction width, saturate
	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			sum_d[r] = SUM_W'(pair_s2[r][0]) + SUM_W'(pair_s2[r][1]);
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready) begin
			for (int r = 0; r < DIM; r++) begin
				res_s3[r] <= sat_q16(sum_d[r][SUM_W-1:FRAC_W]);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_free) begin
			res_q <= res_s3;
		end
	end

	assign out.valid = out_valid_q;
	assign out.out_x = res_q[0];
	assign out.out_y = res_q[1];
	assign out.out_z = res_q[2];
	assign out.out_w = res_q[3];

endmodule

@@ rtl/matrix_vector_transform_4x4.sv @@
// top level of the 4x4 matrix-vector transform engine
//
// channel  dir  handshake     payload
// in       in   valid/ready   opcode, row_select, comp_x..comp_w
// out      out  valid/ready   out_x..out_w
//
// one item per cycle sustained while the output is not stalled; a transform
// item is taken into the front register, then the queue, product, pair-sum,
// final-sum and output registers follow
// the sixteen multipliers of the product stage all work in the same cycle
// reset gives the identity matrix and empties front, queue and pipeline
// a stalled output fills the pipeline, then the queue, then the front register
module matrix_vector_transform_4x4 import mvt_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	mvt_in_if.sink    in,
	mvt_out_if.source out
);

	logic    f_valid;
	cmd_t    f_cmd;
	logic    q_in_ready;
	logic    q_valid;
	cmd_t    q_cmd;
	logic    b_ready;
	q_stat_t q_stat;

	// front end
	mvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.cmd_valid (f_valid),
		.cmd       (f_cmd),
		.cmd_ready (q_in_ready)
	);

	// queue between front and back
	mvt_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_cmd    (f_cmd),
		.in_ready  (q_in_ready),
		.out_valid (q_valid),
		.out_cmd   (q_cmd),
		.out_ready (b_ready),
		.stat      (q_stat)
	);

	// back end
	mvt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_ready (b_ready),
		.out       (out)
	);

	// queue never reports full and empty at once
	a_q_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty together");

	// queue is written only while it has room
	a_q_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.push |-> !q_stat.full)
		else $error("push into full queue");

	// back never takes from an empty queue
	a_q_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// a front item blocked by a full queue is still held next cycle
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && q_stat.full && !q_stat.pop) |=> f_valid)
		else $error("front item lost while queue full");

endmodule

@@ bench/mvt_transform_checker.sv @@
`timescale 1ns / 100ps
// result checker for the matrix-vector transform: predicts every transform and compares results
module mvt_transform_checker import mvt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mvt_in_if    items,
	mvt_out_if   results,
	output int   mismatches,
	output int   outstanding
);

	localparam int REPORT_LIMIT = 10;

	typedef logic [DIM-1:0][COMP_W-1:0] vertex_t;

	// local copy of the matrix, row-major
	logic signed [COMP_W-1:0] coeff [DIM][DIM];
	// transformed vertices not yet seen on the output
	vertex_t expected_vertices [$];

	// matrix times vector: exact wide sum, floor shift, clamp to 32 bits
	function automatic vertex_t transform_vertex(input vertex_t vec);
		vertex_t                  res;
		logic signed [SUM_W-1:0]  acc;
		longint                   a;
		longint                   b;
		longint                   q;
		for (int r = 0; r < DIM; r++) begin
			acc = '0;
			for (int c = 0; c < DIM; c++) begin
				a = coeff[r][c];
				b = signed'(vec[c]);
				acc = acc + (a * b);
			end
			q = longint'(acc >>> FRAC_W);
			if (q > longint'(signed'(Q_MAX))) begin
				q = longint'(signed'(Q_MAX));
			end else if (q < longint'(signed'(Q_MIN))) begin
				q = longint'(signed'(Q_MIN));
			end
			res[r] = q[COMP_W-1:0];
		end
		return res;
	endfunction

	task automatic check_lane(input string tag, input logic [COMP_W-1:0] want,
		input logic [COMP_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("%0t: mismatch on %s: expected %h, got %h", $realtime, tag, want, got);
			end
		end
	endtask

	// follow both channels; results are taken before the item of the same edge
	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		vertex_t vec;
		if (!arst_n) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					coeff[r][c] = (r == c) ? Q_ONE : '0;
				end
			end
			expected_vertices.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// compare a result against the oldest prediction
			if (results.valid && results.ready) begin
				if (expected_vertices.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%0t: result with no transform pending: %h %h %h %h",
							$realtime, results.out_x, results.out_y, results.out_z,
							results.out_w);
					end
				end else begin
					want = expected_vertices.pop_front();
					check_lane("out_x", want[0], results.out_x);
					check_lane("out_y", want[1], results.out_y);
					check_lane("out_z", want[2], results.out_z);
					check_lane("out_w", want[3], results.out_w);
				end
			end
			// apply a row load or predict a transform
			if (items.valid && items.ready) begin
				vec[0] = items.comp_x;
				vec[1] = items.comp_y;
				vec[2] = items.comp_z;
				vec[3] = items.comp_w;
				if (items.opcode == OP_LOAD) begin
					for (int c = 0; c < DIM; c++) begin
						coeff[items.row_select][c] = vec[c];
					end
				end else begin
					expected_vertices.push_back(transform_vertex(vec));
				end
			end
			outstanding = expected_vertices.size();
		end
	end

endmodule

@@ bench/matrix_vector_transform_4x4_test.sv @@
`timescale 1ns / 100ps
// top of the transform testbench: clock, reset, item stimulus, output stalls and verdict
module matrix_vector_transform_4x4_test;
	import mvt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 300;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycle_count = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_ack;
	int   hold_left;

	mvt_in_if  item_ch ();
	mvt_out_if result_ch ();

	matrix_vector_transform_4x4 u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (item_ch),
		.out    (result_ch)
	);

	mvt_transform_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (item_ch),
		.results     (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// output side: random stalls, plus one long hold when requested
	initial begin : result_sink
		result_ch.ready <= 1'b0;
		hold_ack = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				result_ch.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = HOLD_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// component value: full range, small q16.16, extremes or scaled
	function automatic logic [COMP_W-1:0] pick_comp();
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5, 6: v = int'($urandom_range(524288)) - 262144;
			7: begin
				case ($urandom_range(6))
					0: v = Q_MAX;
					1: v = Q_MIN;
					2: v = 0;
					3: v = -1;
					4: v = 1;
					5: v = Q_ONE;
					default: v = -Q_ONE;
				endcase
			end
			8: begin
				v = $urandom >> $urandom_range(31);
				if ($urandom_range(1) == 1) begin
					v = -v;
				end
			end
			default: v = int'($urandom_range(131070)) - 65535;
		endcase
		return v;
	endfunction

	// offer one item, with a random gap first, and wait until it is taken
	task automatic send_item(input opcode_t op, input logic [ROW_W-1:0] row,
		input logic [COMP_W-1:0] x, input logic [COMP_W-1:0] y,
		input logic [COMP_W-1:0] z, input logic [COMP_W-1:0] w);
		logic taken;
		if ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_ch.valid      <= 1'b1;
		item_ch.opcode     <= op;
		item_ch.row_select <= row;
		item_ch.comp_x     <= x;
		item_ch.comp_y     <= y;
		item_ch.comp_z     <= z;
		item_ch.comp_w     <= w;
		do begin
			@(negedge clk);
			taken = item_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// mostly transforms, about a quarter row loads
	task automatic send_random_item();
		opcode_t op;
		op = ($urandom_range(99) < 25) ? OP_LOAD : OP_XFORM;
		send_item(op, ROW_W'($urandom_range(DIM - 1)), pick_comp(), pick_comp(),
			pick_comp(), pick_comp());
	endtask

	task automatic run_phase(input int count, input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct <= stall;
		repeat (count) send_random_item();
	endtask

	// stop offering and wait for every pending transform to come out
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		arst_n             <= 1'b0;
		item_ch.valid      <= 1'b0;
		item_ch.opcode     <= OP_LOAD;
		item_ch.row_select <= '0;
		item_ch.comp_x     <= '0;
		item_ch.comp_y     <= '0;
		item_ch.comp_z     <= '0;
		item_ch.comp_w     <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset matrix is the identity, row select ignored by a transform
		send_item(OP_XFORM, 2'd0, 32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000, Q_ONE);
		send_item(OP_XFORM, 2'd3, Q_MAX, Q_MIN, 32'h0, 32'hFFFF_FFFF);
		// products of magnitude up to 2^62: the wide sum must not wrap
		for (int r = 0; r < DIM; r++) begin
			send_item(OP_LOAD, ROW_W'(r), Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		end
		send_item(OP_XFORM, 2'd1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_item(OP_XFORM, 2'd2, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		// floor of tiny sums of both signs, mixed rows, overflow both ways
		send_item(OP_LOAD, 2'd0, 32'h1, 32'h1, 32'h1, 32'h1);
		send_item(OP_LOAD, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_LOAD, 2'd2, Q_ONE, Q_ONE, -Q_ONE, 32'h0000_8000);
		send_item(OP_LOAD, 2'd3, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_item(OP_XFORM, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_XFORM, 2'd1, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_item(OP_XFORM, 2'd2, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_item(OP_XFORM, 2'd3, 32'h0000_7FFF, 32'h0000_8000, 32'hFFFF_8001, Q_ONE);

		// back to back on both sides
		run_phase(PHASE_ITEMS, 0, 0);

		// long output hold while items keep coming, then a full drain
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		hold_req <= ~hold_req;
		repeat (60) send_item(OP_XFORM, ROW_W'($urandom_range(DIM - 1)), pick_comp(),
			pick_comp(), pick_comp(), pick_comp());
		wait_drained();

		run_phase(PHASE_ITEMS, 74, 0);
		run_phase(PHASE_ITEMS, 0, 74);
		run_phase(PHASE_ITEMS, 9, 9);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
